// ----- design/dda_line_rasterizer_top_defines.svh -----
// assertion macros used by the rasteriser top module
`ifndef DDA_LINE_RASTERIZER_TOP_DEFINES_SVH
`define DDA_LINE_RASTERIZER_TOP_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define DDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dda: same-cycle check failed");

// condition holds in the cycle after the trigger
`define DDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dda: next-cycle check failed");

`endif

// ----- design/dda_pkg.sv -----
`default_nettype none

package dda_pkg;

    // input item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_ADV  = 1'b1;

    // accumulator control from the sequencer
    typedef struct packed {
        logic load;
        logic adv;
    } t_acc_ctrl;

endpackage

`default_nettype wire

// ----- design/dda_div.sv -----
`default_nettype none

module dda_div #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [COORD_BITS-1:0] i_mag,
    input  wire logic [COORD_BITS-1:0] i_steps,
    output logic                       o_done,
    output logic [FRAC_BITS:0]         o_quot
);
    import dda_pkg::*;

    localparam int N  = COORD_BITS + FRAC_BITS + 2;
    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(FRAC_BITS);

    logic [COORD_BITS:0]   r_rem, n_rem;
    logic [FRAC_BITS:0]    r_low, n_low;
    logic [COORD_BITS:0]   r_div, n_div;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_run, n_run;
    logic                  r_done, n_done;

    logic [N-1:0]          w_dvd;
    logic [COORD_BITS+1:0] w_trial;
    logic [COORD_BITS+1:0] w_diff;
    logic                  w_fit;

    // dividend 2*mag*2^frac + steps, rounds the quotient to nearest
    assign w_dvd = {1'b0, i_mag, {(FRAC_BITS+1){1'b0}}} + {{(FRAC_BITS+2){1'b0}}, i_steps};

    // one restoring step a cycle
    assign w_trial = {r_rem, r_low[FRAC_BITS]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_rem  = r_rem;
        n_low  = r_low;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_start) begin
            n_rem = w_dvd[N-1:FRAC_BITS+1];
            n_low = w_dvd[FRAC_BITS:0];
            n_div = {i_steps, 1'b0};
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            n_rem = w_fit ? w_diff[COORD_BITS:0] : w_trial[COORD_BITS:0];
            n_low = {r_low[FRAC_BITS-1:0], w_fit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_CNT) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_low <= n_low;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

`default_nettype wire

// ----- design/dda_acc.sv -----
`default_nettype none

module dda_acc #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire dda_pkg::t_acc_ctrl                   i_ctrl,
    input  wire logic [COORD_BITS-1:0]                i_start,
    input  wire logic signed [COORD_BITS+FRAC_BITS:0] i_step,
    output logic [COORD_BITS-1:0]                     o_coord
);
    import dda_pkg::*;

    localparam int A = COORD_BITS + FRAC_BITS;

    logic [A-1:0]      r_acc, n_acc;
    logic signed [A+1:0] w_sum;

    // saturating add of the signed increment
    assign w_sum = $signed({2'b00, r_acc}) + $signed({i_step[A], i_step});

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.load) begin
            n_acc = {i_start, {FRAC_BITS{1'b0}}};
        end else if (i_ctrl.adv) begin
            if (w_sum[A+1]) begin
                n_acc = '0;
            end else if (w_sum[A]) begin
                n_acc = '1;
            end else begin
                n_acc = w_sum[A-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_coord = r_acc[A-1:FRAC_BITS];

endmodule

`default_nettype wire

// ----- design/dda_line_rasterizer_top.sv -----
// dda line rasteriser
// input channel (i_in_valid / o_in_stall) carries i_func and the endpoints.
// a load (func 0) sets up a line; an advance (func 1) emits the next point
// on the output channel (o_out_valid / i_out_stall) with o_last flagging
// the final one of steps+1 points. an advance with no line open is dropped.
// a load with a non-zero length runs the shared restoring divider twice,
// once per axis, at one quotient bit per cycle: the input stalls after
// the load transfer until both axis increments are stored.
// a zero-length load leaves the divider idle and sets both increments to zero.
// advances run at one per cycle; each point appears in the output register
// the cycle after its transfer. while the receiver stalls, the point is
// held and further advances stall, loads are still taken.
// a load during a line drops the rest of that line.
// synchronous reset leaves the block idle with no line open.
`default_nettype none

`include "dda_line_rasterizer_top_defines.svh"

module dda_line_rasterizer_top #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_func,
    input  wire logic [COORD_BITS-1:0] i_x_start,
    input  wire logic [COORD_BITS-1:0] i_y_start,
    input  wire logic [COORD_BITS-1:0] i_x_end,
    input  wire logic [COORD_BITS-1:0] i_y_end,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [COORD_BITS-1:0]      o_pixel_x,
    output logic [COORD_BITS-1:0]      o_pixel_y,
    output logic                       o_last
);
    import dda_pkg::*;

    localparam int A = COORD_BITS + FRAC_BITS;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SX   = 3'd1;
    localparam logic [2:0] S_DX   = 3'd2;
    localparam logic [2:0] S_SY   = 3'd3;
    localparam logic [2:0] S_DY   = 3'd4;

    logic [2:0]              r_state, n_state;
    logic                    r_busy, n_busy;
    logic [COORD_BITS:0]     r_left, n_left;
    logic [COORD_BITS-1:0]   r_ax, r_ay, r_steps;
    logic                    r_x_neg, r_y_neg;
    logic signed [A:0]       r_x_step, r_y_step;
    logic                    r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0]   r_pix_x, r_pix_y;
    logic                    r_last;

    logic                    w_in_xfer, w_load, w_adv;
    logic [COORD_BITS:0]     w_dx, w_dy;
    logic [COORD_BITS-1:0]   w_ax, w_ay, w_steps;
    logic                    w_div_start, w_div_done;
    logic [COORD_BITS-1:0]   w_div_mag;
    logic [FRAC_BITS:0]      w_quot;
    logic signed [A:0]       w_q_ext, w_signed_q;
    logic [COORD_BITS-1:0]   w_cx, w_cy;
    t_acc_ctrl               w_acc_ctrl;
    logic                    w_is_last;

    // input handshake
    assign o_in_stall = (r_state != S_IDLE)
                      | (r_out_valid & i_out_stall & (i_func == FUNC_ADV));
    assign w_in_xfer  = i_in_valid & ~o_in_stall;
    assign w_load     = w_in_xfer & (i_func == FUNC_LOAD);
    assign w_adv      = w_in_xfer & (i_func == FUNC_ADV) & r_busy;
    assign w_is_last  = (r_left <= {{COORD_BITS{1'b0}}, 1'b1});

    // deltas, magnitudes and step count
    assign w_dx    = {1'b0, i_x_end} - {1'b0, i_x_start};
    assign w_dy    = {1'b0, i_y_end} - {1'b0, i_y_start};
    assign w_ax    = w_dx[COORD_BITS] ? COORD_BITS'(-w_dx) : w_dx[COORD_BITS-1:0];
    assign w_ay    = w_dy[COORD_BITS] ? COORD_BITS'(-w_dy) : w_dy[COORD_BITS-1:0];
    assign w_steps = (w_ax > w_ay) ? w_ax : w_ay;

    // shared divider, x then y
    assign w_div_start = (r_state == S_SX) | (r_state == S_SY);
    assign w_div_mag   = (r_state == S_SY) ? r_ay : r_ax;

    dda_div #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_mag  (w_div_mag),
        .i_steps(r_steps),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // apply the delta sign to the rounded magnitude
    assign w_q_ext    = $signed({{COORD_BITS{1'b0}}, w_quot});
    assign w_signed_q = (((r_state == S_DX) & r_x_neg) | ((r_state == S_DY) & r_y_neg))
                      ? -w_q_ext : w_q_ext;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_load && (w_steps != '0)) begin
                    n_state = S_SX;
                end
            end
            S_SX: n_state = S_DX;
            S_DX: begin
                if (w_div_done) begin
                    n_state = S_SY;
                end
            end
            S_SY: n_state = S_DY;
            S_DY: begin
                if (w_div_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // line progress
    always_comb begin
        n_busy = r_busy;
        n_left = r_left;
        if (w_load) begin
            n_busy = 1'b1;
            n_left = {1'b0, w_steps} + 1'b1;
        end else if (w_adv) begin
            if (w_is_last) begin
                n_busy = 1'b0;
                n_left = '0;
            end else begin
                n_left = r_left - 1'b1;
            end
        end
    end

    assign n_out_valid = w_adv | (r_out_valid & i_out_stall);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // line set-up and increments
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ax    <= w_ax;
            r_ay    <= w_ay;
            r_steps <= w_steps;
            r_x_neg <= w_dx[COORD_BITS];
            r_y_neg <= w_dy[COORD_BITS];
            if (w_steps == '0) begin
                r_x_step <= '0;
                r_y_step <= '0;
            end
        end
        if ((r_state == S_DX) && w_div_done) begin
            r_x_step <= w_signed_q;
        end
        if ((r_state == S_DY) && w_div_done) begin
            r_y_step <= w_signed_q;
        end
    end

    // point accumulators
    assign w_acc_ctrl.load = w_load;
    assign w_acc_ctrl.adv  = w_adv;

    dda_acc #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_acc_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_acc_ctrl),
        .i_start(i_x_start),
        .i_step (r_x_step),
        .o_coord(w_cx)
    );

    dda_acc #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_acc_y (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_acc_ctrl),
        .i_start(i_y_start),
        .i_step (r_y_step),
        .o_coord(w_cy)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pix_x <= w_cx;
            r_pix_y <= w_cy;
            r_last  <= w_is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_pix_x;
    assign o_pixel_y   = r_pix_y;
    assign o_last      = r_last;

    // checks
    `DDA_ASSERT_SAME(a_stall_in_setup, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `DDA_ASSERT_SAME(a_open_line_count, i_clk, i_rst_n, r_busy, r_left != '0)
    `DDA_ASSERT_NEXT(a_adv_gives_point, i_clk, i_rst_n, w_adv, o_out_valid)
    `DDA_ASSERT_NEXT(a_last_closes_line, i_clk, i_rst_n, w_adv && w_is_last, !r_busy && o_last)

endmodule

`default_nettype wire

// ----- test/dda_checker.sv -----
`default_nettype none

module dda_checker #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic                  i_func,
    input  wire logic [COORD_BITS-1:0] i_x_start,
    input  wire logic [COORD_BITS-1:0] i_y_start,
    input  wire logic [COORD_BITS-1:0] i_x_end,
    input  wire logic [COORD_BITS-1:0] i_y_end,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [COORD_BITS-1:0] i_pixel_x,
    input  wire logic [COORD_BITS-1:0] i_pixel_y,
    input  wire logic                  i_last,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dda_pkg::*;

    localparam int     ACC_W   = COORD_BITS + FRAC_BITS;
    localparam longint ACC_TOP = (64'sd1 <<< ACC_W) - 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  last;
    } t_point;

    // points still owed by the block, oldest first
    t_point expected_points[$];

    // own copy of the line state
    logic [ACC_W-1:0]    pos_x;
    logic [ACC_W-1:0]    pos_y;
    longint              inc_x;
    longint              inc_y;
    logic [COORD_BITS:0] points_left;
    logic                line_open;
    int                  mismatches;

    // delta / span in fixed point, magnitude rounded half away from zero
    function automatic longint rounded_slope(longint delta, longint span);
        longint mag;
        longint num;
        longint q;
        mag = (delta < 0) ? -delta : delta;
        num = mag <<< FRAC_BITS;
        q   = (2 * num + span) / (2 * span);
        return (delta < 0) ? -q : q;
    endfunction

    // accumulator add, clamped to the unsigned range
    function automatic logic [ACC_W-1:0] clamp_add(logic [ACC_W-1:0] acc, longint inc);
        longint s;
        s = inc;
        s = s + longint'({1'b0, acc});
        if (s < 0) begin
            s = 0;
        end else if (s > ACC_TOP) begin
            s = ACC_TOP;
        end
        return s[ACC_W-1:0];
    endfunction

    always @(posedge i_clk) begin : check_and_predict
        t_point want;
        longint dx;
        longint dy;
        longint ax;
        longint ay;
        longint span;
        logic   bad;
        if (!i_rst_n) begin
            pos_x        = '0;
            pos_y        = '0;
            inc_x        = 0;
            inc_y        = 0;
            points_left  = '0;
            line_open    = 1'b0;
            mismatches   = 0;
            expected_points.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            // output transfer against the oldest owed point
            if (i_out_valid && !i_out_stall) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: point with none owed, x=%0d y=%0d last=%0d",
                             $time, i_pixel_x, i_pixel_y, i_last);
                    mismatches++;
                end else begin
                    want = expected_points.pop_front();
                    bad  = 1'b0;
                    if (i_pixel_x !== want.px) begin
                        $display("%0t: pixel_x expected %0d got %0d",
                                 $time, want.px, i_pixel_x);
                        bad = 1'b1;
                    end
                    if (i_pixel_y !== want.py) begin
                        $display("%0t: pixel_y expected %0d got %0d",
                                 $time, want.py, i_pixel_y);
                        bad = 1'b1;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last expected %0d got %0d",
                                 $time, want.last, i_last);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        mismatches++;
                    end
                end
            end

            // input transfer updates the line state
            if (i_in_valid && !i_in_stall) begin
                if (i_func == FUNC_LOAD) begin
                    dx   = longint'(i_x_end) - longint'(i_x_start);
                    dy   = longint'(i_y_end) - longint'(i_y_start);
                    ax   = (dx < 0) ? -dx : dx;
                    ay   = (dy < 0) ? -dy : dy;
                    span = (ax > ay) ? ax : ay;
                    if (span == 0) begin
                        inc_x = 0;
                        inc_y = 0;
                    end else begin
                        inc_x = rounded_slope(dx, span);
                        inc_y = rounded_slope(dy, span);
                    end
                    pos_x       = {i_x_start, {FRAC_BITS{1'b0}}};
                    pos_y       = {i_y_start, {FRAC_BITS{1'b0}}};
                    points_left = (COORD_BITS + 1)'(span + 1);
                    line_open   = 1'b1;
                end else if (line_open) begin
                    want.px   = pos_x[ACC_W-1:FRAC_BITS];
                    want.py   = pos_y[ACC_W-1:FRAC_BITS];
                    want.last = (points_left <= 1);
                    expected_points.push_back(want);
                    pos_x = clamp_add(pos_x, inc_x);
                    pos_y = clamp_add(pos_y, inc_y);
                    if (points_left <= 1) begin
                        points_left = '0;
                        line_open   = 1'b0;
                    end else begin
                        points_left = points_left - 1'b1;
                    end
                end
            end

            o_fail_count <= mismatches;
            o_pending    <= expected_points.size();
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_dda_line_rasterizer_top.sv -----
`default_nettype none

module tb_dda_line_rasterizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dda_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int CMAX       = (1 << COORD_BITS) - 1;
    localparam int LOAD_ITEMS = 950;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  func;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic                  out_valid;
    logic                  out_stall;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;
    int                    fail_count;
    int                    pending;

    // idling odds in percent, changed per phase
    int gap_pct;
    int stall_pct;

    dda_line_rasterizer_top #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_func     (func),
        .i_x_start  (x_start),
        .i_y_start  (y_start),
        .i_x_end    (x_end),
        .i_y_end    (y_end),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_pixel_x  (pixel_x),
        .o_pixel_y  (pixel_y),
        .o_last     (last)
    );

    dda_checker #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_func      (func),
        .i_x_start   (x_start),
        .i_y_start   (y_start),
        .i_x_end     (x_end),
        .i_y_end     (y_end),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_pixel_x   (pixel_x),
        .i_pixel_y   (pixel_y),
        .i_last      (last),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAIL dda_line_rasterizer_top");
        $finish;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // one input transfer, with an optional idle gap ahead of it
    task automatic send_item(input logic f, input logic [COORD_BITS-1:0] xs,
                             input logic [COORD_BITS-1:0] ys,
                             input logic [COORD_BITS-1:0] xe,
                             input logic [COORD_BITS-1:0] ye);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        x_start  <= xs;
        y_start  <= ys;
        x_end    <= xe;
        y_end    <= ye;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // random coordinate over the whole range
    function automatic logic [COORD_BITS-1:0] any_coord();
        return COORD_BITS'($urandom_range(0, CMAX));
    endfunction

    // advance with junk endpoints, which the block ignores
    task automatic advance();
        send_item(FUNC_ADV, any_coord(), any_coord(), any_coord(), any_coord());
    endtask

    // coordinate a bounded distance from a base, kept in range
    function automatic logic [COORD_BITS-1:0] near(logic [COORD_BITS-1:0] base, int spread);
        int v;
        v = int'($urandom_range(0, 2 * spread)) - spread + int'(base);
        if (v < 0) begin
            v = 0;
        end else if (v > CMAX) begin
            v = CMAX;
        end
        return v[COORD_BITS-1:0];
    endfunction

    // random start coordinate, sometimes at an edge of the range
    function automatic logic [COORD_BITS-1:0] pick_start();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end else if (r < 10) begin
            return CMAX[COORD_BITS-1:0];
        end
        return any_coord();
    endfunction

    initial begin : stimulus
        int                    items;
        int                    spread;
        int                    span;
        int                    n;
        int                    r;
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ye;
        logic                  f;

        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        func      <= FUNC_LOAD;
        x_start   <= '0;
        y_start   <= '0;
        x_end     <= '0;
        y_end     <= '0;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // advance with no line open
        advance();
        // zero-length line: one advance for its single point, then one with no line open
        send_item(FUNC_LOAD, 12'd100, 12'd200, 12'd100, 12'd200);
        advance();
        advance();
        // full-range diagonal, cut short by a new load
        send_item(FUNC_LOAD, '0, '0, CMAX[COORD_BITS-1:0], CMAX[COORD_BITS-1:0]);
        repeat (3) advance();
        send_item(FUNC_LOAD, CMAX[COORD_BITS-1:0], '0, '0, CMAX[COORD_BITS-1:0]);
        repeat (3) advance();
        // rounding overshoot below zero on the last point
        send_item(FUNC_LOAD, 12'd0, 12'd3, 12'd7, 12'd0);
        repeat (8) advance();

        // random lines over four idling phases
        items = 0;
        while (items < LOAD_ITEMS) begin
            case (items * 4 / LOAD_ITEMS)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 48; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 48; end
                default: begin gap_pct = 32; stall_pct = 32; end
            endcase
            r = $urandom_range(0, 99);
            if (r < 85) begin
                // well-formed line with a short span most of the time
                spread = ($urandom_range(0, 99) < 5) ? 100 : 24;
                xs = pick_start();
                ys = pick_start();
                xe = near(xs, spread);
                ye = near(ys, spread);
                span = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
                if (((ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye)) > span) begin
                    span = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
                end
                send_item(FUNC_LOAD, xs, ys, xe, ye);
                items++;
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    n = span + 1;
                end else if (r < 85) begin
                    n = $urandom_range(0, span);
                end else begin
                    n = span + 1 + $urandom_range(1, 3);
                end
                for (int i = 0; i < n; i++) begin
                    advance();
                    if (i <= span) begin
                        items++;
                    end
                end
            end else begin
                // noise: any item with any endpoints
                f = 1'($urandom_range(0, 1));
                send_item(f, any_coord(), any_coord(), any_coord(), any_coord());
                if (f == FUNC_LOAD) begin
                    items++;
                end
            end
        end
        in_valid <= 1'b0;

        // drain owed points, then let the pipeline settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (48) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS dda_line_rasterizer_top");
        end else begin
            $display("FAIL dda_line_rasterizer_top");
        end
        $finish;
    end

endmodule

`default_nettype wire
